FILE: rtl/core/cfr_pkg.sv
// shared types and constants for the checksummed frame receiver
package cfr_pkg;

  // emit sequencer states
  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_READ,
    ST_LOAD
  } emit_state_t;

  // request from the framer to start emitting a completed frame
  typedef struct packed {
    logic start;
    logic ok;
  } emit_req_t;

  // input item codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // register indexes (address bit 2)
  localparam logic REG_PREAMBLE = 1'b0;
  localparam logic REG_TIMEOUT  = 1'b1;

  localparam logic [7:0]  PREAMBLE_RESET = 8'd59;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd250;
  localparam logic [15:0] IDLE_MAX       = 16'hffff;

endpackage

FILE: rtl/core/checksummed_frame_receiver.sv
// top level: length-prefixed frame receiver with checksum and idle timeout
// a completing checksum beat starts its run, stepping through the READ and LOAD states per entry
// throughput: one input beat per cycle for ticks and non-final bytes while no run is emitted
// a checksum beat stalls input until every entry of its run, length byte included, is loaded (store read per byte)
// synchronous reset restores registers and clears parser and sequencer state
// the frame store holds no reset value; only bytes written in the frame are read
module checksummed_frame_receiver #(
  parameter int MAX_LENGTH = 15
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  data_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  frame_byte,
  output logic [3:0]  byte_number,
  output logic        frame_ok,
  output logic        last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LEN_W = $clog2(MAX_LENGTH + 1);

  // configuration registers
  logic [7:0]  preamble;
  logic [15:0] timeout;

  // parser / store wiring
  logic               accept;
  logic               mem_we;
  logic [LEN_W-1:0]   mem_waddr;
  logic [7:0]         mem_wdata;
  logic [7:0]         mem_rdata;
  logic               mem_re;
  cfr_pkg::emit_req_t emit;
  logic [LEN_W-1:0]   frame_len;

  // emit sequencer
  cfr_pkg::emit_state_t state, state_next;
  logic [LEN_W-1:0]     rd_idx;
  logic [LEN_W-1:0]     emit_len;
  logic                 emit_ok;
  logic                 out_free;
  logic                 load;
  logic                 at_last;

  // ---------------------------------------------------------------
  // configuration port, always ready
  // ---------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble <= cfr_pkg::PREAMBLE_RESET;
      timeout  <= cfr_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        cfr_pkg::REG_PREAMBLE: preamble <= pwdata[7:0];
        cfr_pkg::REG_TIMEOUT:  timeout  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      cfr_pkg::REG_PREAMBLE: prdata = {24'd0, preamble};
      cfr_pkg::REG_TIMEOUT:  prdata = {16'd0, timeout};
      default:               prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------
  // input side: beats are taken only while no run is being emitted
  // ---------------------------------------------------------------
  assign in_stall = (state != cfr_pkg::ST_ACCEPT);
  assign accept   = in_valid && !in_stall;

  cfr_parse #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cmd       (cmd),
    .data_byte (data_byte),
    .preamble  (preamble),
    .timeout   (timeout),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .emit      (emit),
    .frame_len (frame_len)
  );

  // frame bytes, length byte at entry zero
  cfr_store #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_idx),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------
  // emit sequencer: read one entry, then load it into the output
  // register once that register is free
  // ---------------------------------------------------------------
  assign out_free = !out_valid || !out_stall;
  assign at_last  = (rd_idx == emit_len);

  always_comb begin
    state_next = state;
    unique case (state)
      cfr_pkg::ST_ACCEPT: begin
        if (emit.start) begin
          state_next = cfr_pkg::ST_READ;
        end
      end
      cfr_pkg::ST_READ: begin
        state_next = cfr_pkg::ST_LOAD;
      end
      cfr_pkg::ST_LOAD: begin
        if (out_free) begin
          state_next = at_last ? cfr_pkg::ST_ACCEPT : cfr_pkg::ST_READ;
        end
      end
      default: state_next = cfr_pkg::ST_ACCEPT;
    endcase
  end

  always_comb begin
    mem_re = (state == cfr_pkg::ST_READ);
    load   = (state == cfr_pkg::ST_LOAD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfr_pkg::ST_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

  // run bookkeeping, latched when the checksum beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx   <= '0;
      emit_len <= '0;
      emit_ok  <= 1'b0;
    end else if (emit.start) begin
      rd_idx   <= '0;
      emit_len <= frame_len;
      emit_ok  <= emit.ok;
    end else if (load && !at_last) begin
      rd_idx <= rd_idx + LEN_W'(1);
    end
  end

  // output register, parts the sequencer from the output stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_byte  <= mem_rdata;
      byte_number <= 4'(rd_idx);
      frame_ok    <= emit_ok;
      last        <= at_last;
    end
  end

`ifndef SYNTHESIS
  // the store is never written while a run is being read out
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == cfr_pkg::ST_ACCEPT)
    else $error("frame store written during emission");

  // read index stays inside the run
  assert property (@(posedge clk) disable iff (rst)
    state != cfr_pkg::ST_ACCEPT |-> rd_idx <= emit_len)
    else $error("read index past run length");

  // an output beat only appears after a store read was loaded
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == cfr_pkg::ST_LOAD)
    else $error("output beat without store read");
`endif

endmodule

FILE: rtl/core/cfr_store.sv
// frame byte store: one write port, one registered read port
module cfr_store #(
  parameter int MAX_LENGTH = 15,
  localparam int LEN_W = $clog2(MAX_LENGTH + 1)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [LEN_W-1:0] waddr,
  input  logic [7:0]       wdata,
  input  logic             re,
  input  logic [LEN_W-1:0] raddr,
  output logic [7:0]       rdata
);

  logic [7:0] mem [MAX_LENGTH + 1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/cfr_parse.sv
// frame parser: preamble, length, body, checksum and idle timeout
module cfr_parse #(
  parameter int MAX_LENGTH = 15,
  localparam int LEN_W = $clog2(MAX_LENGTH + 1),
  localparam int POS_W = $clog2(MAX_LENGTH + 3)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                cmd,
  input  logic [7:0]          data_byte,
  input  logic [7:0]          preamble,
  input  logic [15:0]         timeout,
  output logic                mem_we,
  output logic [LEN_W-1:0]    mem_waddr,
  output logic [7:0]          mem_wdata,
  output cfr_pkg::emit_req_t  emit,
  output logic [LEN_W-1:0]    frame_len
);

  logic             in_frame, in_frame_next;
  logic             have_length, have_length_next;
  logic             timing_active, timing_active_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [LEN_W-1:0] len, len_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [15:0]      idle_count, idle_count_next;

  always_comb begin
    logic go_idle;
    go_idle            = 1'b0;
    in_frame_next      = in_frame;
    have_length_next   = have_length;
    timing_active_next = timing_active;
    pos_next           = pos;
    len_next           = len;
    running_sum_next   = running_sum;
    idle_count_next    = idle_count;
    mem_we             = 1'b0;
    mem_waddr          = '0;
    mem_wdata          = data_byte;
    emit               = '0;

    if (accept) begin
      if (cmd == cfr_pkg::CMD_TICK) begin
        if (timing_active && idle_count != cfr_pkg::IDLE_MAX) begin
          idle_count_next = idle_count + 16'd1;
        end
      end else if (timing_active && idle_count > timeout) begin
        // late byte is dropped
        go_idle = 1'b1;
      end else if (!in_frame) begin
        if (data_byte == preamble) begin
          in_frame_next      = 1'b1;
          have_length_next   = 1'b0;
          pos_next           = POS_W'(1);
          running_sum_next   = 8'd0;
          timing_active_next = 1'b1;
          idle_count_next    = 16'd0;
        end
      end else begin
        timing_active_next = 1'b1;
        idle_count_next    = 16'd0;
        if (!have_length) begin
          if (data_byte > 8'(MAX_LENGTH)) begin
            go_idle = 1'b1;
          end else begin
            have_length_next = 1'b1;
            mem_we           = 1'b1;
            mem_waddr        = '0;
            running_sum_next = data_byte;
            pos_next         = POS_W'(2);
            len_next         = data_byte[LEN_W-1:0];
          end
        end else if (pos < POS_W'(len) + POS_W'(2)) begin
          // body byte
          mem_we           = 1'b1;
          mem_waddr        = LEN_W'(pos - POS_W'(1));
          running_sum_next = running_sum + data_byte;
          pos_next         = pos + POS_W'(1);
        end else begin
          // checksum byte
          emit.start = 1'b1;
          emit.ok    = (data_byte != 8'd0) && (data_byte == (8'd0 - running_sum));
          go_idle    = 1'b1;
        end
      end
    end

    if (go_idle) begin
      in_frame_next      = 1'b0;
      have_length_next   = 1'b0;
      pos_next           = '0;
      running_sum_next   = 8'd0;
      timing_active_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      have_length   <= 1'b0;
      timing_active <= 1'b0;
      pos           <= '0;
      len           <= '0;
      running_sum   <= 8'd0;
      idle_count    <= 16'd0;
    end else begin
      in_frame      <= in_frame_next;
      have_length   <= have_length_next;
      timing_active <= timing_active_next;
      pos           <= pos_next;
      len           <= len_next;
      running_sum   <= running_sum_next;
      idle_count    <= idle_count_next;
    end
  end

  assign frame_len = len;

endmodule
